>>> rtl/core/hrlp_pkg.sv
`timescale 1ns / 1ps

package hrlp_pkg;

  // Size of the token buffer; a token counts at most one byte fewer than this, and further bytes overflow.
  localparam int TOKEN_BUFFER_BYTES = 16;
  localparam int IDX_W = $clog2(TOKEN_BUFFER_BYTES);
  // Only the first three bytes of a token ever take part in a comparison.
  localparam int PREFIX_BYTES = 3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_V     = 8'h76;

  typedef enum logic [1:0] {
    PH_DONE    = 2'd0,
    PH_VERSION = 2'd1,
    PH_URI     = 2'd2,
    PH_METHOD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD         = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_NOT_ALLOWED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RT_NONE    = 2'd0,
    RT_ROOT    = 2'd1,
    RT_VERSION = 2'd2
  } route_t;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic    aborted;
    status_t status;
    route_t  route;
  } result_t;

endpackage

>>> rtl/core/hrlp_in_stage.sv
`timescale 1ns / 1ps

module hrlp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hrlp_pkg::item_t in_item,
  output logic           held_valid,
  output hrlp_pkg::item_t held_item,
  input  logic           advance
);
  import hrlp_pkg::*;

  // The held word moves on whenever the downstream side can take it.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

>>> rtl/core/hrlp_parser.sv
`timescale 1ns / 1ps

module hrlp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  hrlp_pkg::item_t   item,
  output logic              res_valid,
  output hrlp_pkg::result_t res
);
  import hrlp_pkg::*;

  phase_t           phase, phase_next;
  logic             line_blank, line_blank_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] token_length, token_length_next;
  logic [7:0]       prefix [PREFIX_BYTES];
  logic [7:0]       prefix_next [PREFIX_BYTES];
  status_t          status_code, status_code_next;
  route_t           route_found, route_found_next;

  logic is_close, is_lf, is_cr, is_space, ends_request;
  logic tok_get, tok_root, tok_ver;

  assign is_close     = (item.kind == KIND_CLOSE);
  assign is_lf        = (item.byte_value == CH_LF);
  assign is_cr        = (item.byte_value == CH_CR);
  assign is_space     = (item.byte_value == CH_SPACE);
  assign ends_request = is_close || (is_lf && line_blank);

  assign tok_get  = (token_length == IDX_W'(3)) && (prefix[0] == CH_G)
                    && (prefix[1] == CH_E) && (prefix[2] == CH_T);
  assign tok_root = (token_length == IDX_W'(1)) && (prefix[0] == CH_SLASH);
  assign tok_ver  = (token_length == IDX_W'(2)) && (prefix[0] == CH_SLASH)
                    && (prefix[1] == CH_V);

  // Next-state logic for one byte or disconnect.
  always_comb begin
    phase_next        = phase;
    line_blank_next   = line_blank;
    write_index_next  = write_index;
    token_length_next = token_length;
    status_code_next  = status_code;
    route_found_next  = route_found;
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      prefix_next[i] = prefix[i];
    end

    if (ends_request) begin
      phase_next       = PH_METHOD;
      line_blank_next  = 1'b1;
      write_index_next = '0;
      status_code_next = ST_OK;
      route_found_next = RT_NONE;
    end else if (!is_cr) begin
      line_blank_next = is_lf;
      if (phase != PH_DONE) begin
        if (is_space || is_lf) begin
          write_index_next = '0;
          unique case (phase)
            PH_METHOD: begin
              if (is_lf) begin
                status_code_next = ST_BAD;
                phase_next       = PH_DONE;
              end else if (tok_get) begin
                phase_next = PH_URI;
              end else begin
                status_code_next = ST_NOT_ALLOWED;
                phase_next       = PH_DONE;
              end
            end
            PH_URI: begin
              if (is_lf) begin
                status_code_next = ST_BAD;
                phase_next       = PH_DONE;
              end else if (tok_root) begin
                route_found_next = RT_ROOT;
                phase_next       = PH_VERSION;
              end else if (tok_ver) begin
                route_found_next = RT_VERSION;
                phase_next       = PH_VERSION;
              end else begin
                status_code_next = ST_NOT_FOUND;
                phase_next       = PH_DONE;
              end
            end
            PH_VERSION: begin
              if (!is_lf) begin
                status_code_next = ST_BAD;
              end
              phase_next = PH_DONE;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end else if (write_index != IDX_W'(TOKEN_BUFFER_BYTES - 1)) begin
          for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (write_index == IDX_W'(i)) begin
              prefix_next[i] = item.byte_value;
            end
          end
          write_index_next  = write_index + 1'b1;
          token_length_next = write_index + 1'b1;
        end else if (phase == PH_METHOD) begin
          status_code_next = ST_NOT_ALLOWED;
        end else if (phase == PH_URI) begin
          status_code_next = ST_NOT_FOUND;
        end else begin
          status_code_next = ST_BAD;
        end
      end
    end
  end

  // Result for the current item.
  always_comb begin
    res_valid = ends_request;
    if (is_close) begin
      res.aborted = 1'b1;
      res.status  = ST_OK;
      res.route   = RT_NONE;
    end else begin
      res.aborted = 1'b0;
      res.status  = status_code;
      res.route   = (status_code == ST_OK) ? route_found : RT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_METHOD;
      line_blank   <= 1'b1;
      write_index  <= '0;
      token_length <= '0;
      status_code  <= ST_OK;
      route_found  <= RT_NONE;
    end else if (step) begin
      phase        <= phase_next;
      line_blank   <= line_blank_next;
      write_index  <= write_index_next;
      token_length <= token_length_next;
      status_code  <= status_code_next;
      route_found  <= route_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < PREFIX_BYTES; i++) begin
        prefix[i] <= prefix_next[i];
      end
    end
  end

endmodule

>>> rtl/core/hrlp_out_stage.sv
`timescale 1ns / 1ps

module hrlp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hrlp_pkg::result_t load_res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output hrlp_pkg::result_t out_res
);
  import hrlp_pkg::*;

  logic out_valid_next;

  // The register can take a new result once the current one is gone or leaves now.
  assign advance = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_res <= load_res;
    end
  end

endmodule

>>> rtl/core/http_request_line_parser_core.sv
`timescale 1ns / 1ps
// Each word passes through the input register; a result it produces is then loaded into the output register.
// Throughput: one word per cycle unless stalled as below; the parser state is updated once per word.
// Stalls only come from the master side holding tready low while a result is pending.
// Reset (rst, synchronous, active high) empties both stages and returns the parser to
// expecting a method; the kept token bytes are not cleared and are only compared once written.

module http_request_line_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tuser,   // [0] kind (1 = connection closed by peer)
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] route, [3:2] status, [4] aborted, [7:5] zero
);
  import hrlp_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.kind       = kind_t'(s_tuser);
  assign in_item.byte_value = s_tdata;

  // The input register holds one word; it is consumed whenever the result
  // register can take whatever that word produces.
  hrlp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  // A held word updates the parser state in the cycle it leaves the input register.
  assign step = held_valid && advance;

  hrlp_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  hrlp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (res),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res.aborted, out_res.status, out_res.route};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hrlp_pkg::*;

  // A queued word, or a marker that makes the sender wait for every result.
  typedef struct packed {
    logic       drain;
    kind_t      kind;
    logic [7:0] value;
  } stim_t;

  localparam int HOLD_FROM   = 400;   // receiver cycle at which the long stall starts
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int WORD_TARGET = 1200;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  http_request_line_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  stim_t   pending_words[$];
  result_t expected_results[$];

  // Parser state as the predictor sees it.
  phase_t     req_phase;
  bit         at_line_start;
  int         tok_widx;
  int         tok_len;
  logic [7:0] tok_bytes [TOKEN_BUFFER_BYTES];
  status_t    req_status;
  route_t     req_route;

  int failures = 0;
  int words_taken = 0;
  int closes_taken = 0;
  int results_seen = 0;
  int aborted_seen = 0;
  int roots_seen = 0;
  int versions_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int drains_done = 0;
  int quiet_cycles = 0;

  task automatic note_failure(input string what);
    failures++;
    if (failures <= 10) $display("testbench: MISMATCH %s", what);
  endtask

  task automatic start_request();
    req_phase     = PH_METHOD;
    at_line_start = 1'b1;
    tok_widx      = 0;
    req_status    = ST_OK;
    req_route     = RT_NONE;
  endtask

  // Tokens compare by length and content; only written entries are ever read.
  function automatic bit token_matches(input string lit);
    bit same;
    same = (tok_len == lit.len());
    for (int i = 0; i < lit.len(); i++)
      if (same && tok_bytes[i] != lit[i]) same = 1'b0;
    return same;
  endfunction

  // Advances the parser by one word and says whether a result comes of it.
  task automatic parse_word(input kind_t kind, input logic [7:0] ch, output bit emits,
                            output result_t res);
    res   = '0;
    emits = 1'b0;
    if (kind == KIND_CLOSE) begin
      res.aborted = 1'b1;
      res.status  = ST_OK;
      res.route   = RT_NONE;
      emits = 1'b1;
      start_request();
    end else if (ch == CH_LF && at_line_start) begin
      res.status = req_status;
      res.route  = (req_status == ST_OK) ? req_route : RT_NONE;
      emits = 1'b1;
      start_request();
    end else if (ch != CH_CR) begin
      at_line_start = (ch == CH_LF);
      if (req_phase != PH_DONE) begin
        if (ch == CH_SPACE || ch == CH_LF) begin
          // An empty token leaves the previous token in place for the comparison.
          case (req_phase)
            PH_METHOD: begin
              if (ch == CH_LF) req_status = ST_BAD;
              else if (!token_matches("GET")) req_status = ST_NOT_ALLOWED;
              req_phase = (ch != CH_LF && token_matches("GET")) ? PH_URI : PH_DONE;
            end
            PH_URI: begin
              if (ch == CH_LF) begin
                req_status = ST_BAD;
                req_phase  = PH_DONE;
              end else if (token_matches("/")) begin
                req_route = RT_ROOT;
                req_phase = PH_VERSION;
              end else if (token_matches("/v")) begin
                req_route = RT_VERSION;
                req_phase = PH_VERSION;
              end else begin
                req_status = ST_NOT_FOUND;
                req_phase  = PH_DONE;
              end
            end
            PH_VERSION: begin
              if (ch != CH_LF) req_status = ST_BAD;
              req_phase = PH_DONE;
            end
            default: ;
          endcase
          tok_widx = 0;
        end else if (tok_widx < TOKEN_BUFFER_BYTES - 1) begin
          tok_bytes[tok_widx] = ch;
          tok_widx++;
          tok_len = tok_widx;
        end else begin
          // Overflowing byte: dropped, and the status follows the phase.
          case (req_phase)
            PH_METHOD: req_status = ST_NOT_ALLOWED;
            PH_URI:    req_status = ST_NOT_FOUND;
            default:   req_status = ST_BAD;
          endcase
        end
      end
    end
  endtask

  // ---- stimulus generation ----
  int cut_at = -1;
  int req_pos = 0;
  bit req_cut = 1'b0;
  int words_queued = 0;
  int drain_at = 900;
  int pick;

  task automatic push_word(input kind_t k, input logic [7:0] v);
    stim_t s;
    s = '0;
    s.kind  = k;
    s.value = v;
    pending_words.push_back(s);
    words_queued++;
  endtask

  // A request byte, with a stray CR now and then and the disconnect cut.
  task automatic push_req_byte(input logic [7:0] v);
    if (!req_cut) begin
      if ($urandom_range(0, 24) == 0) push_word(KIND_BYTE, CH_CR);
      push_word(KIND_BYTE, v);
      req_pos++;
      if (req_pos == cut_at) begin
        push_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
        req_cut = 1'b1;
      end
    end
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) push_req_byte(t[i]);
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    c = CH_SPACE;
    while (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
      case ($urandom_range(0, 7))
        0: c = CH_G;
        1: c = CH_E;
        2: c = CH_T;
        3: c = CH_SLASH;
        4: c = CH_V;
        5: c = 8'h00;
        default: c = 8'($urandom_range(0, 255));
      endcase
    end
    return c;
  endfunction

  task automatic push_random_token(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) push_req_byte(token_char());
  endtask

  task automatic push_delim();
    case ($urandom_range(0, 9))
      8: push_req_byte(CH_LF);
      9: push_text("  ");
      default: push_req_byte(CH_SPACE);
    endcase
  endtask

  // A mostly well-formed request with random content and the odd fault.
  task automatic push_request();
    req_cut = 1'b0;
    req_pos = 0;
    cut_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : -1;
    if ($urandom_range(0, 14) == 0) push_text("\015\012");
    case ($urandom_range(0, 9))
      6: push_random_token(1, 4);
      7: ;
      8: push_random_token(13, 20);
      9: begin
        case ($urandom_range(0, 3))
          0: push_text("GE");
          1: push_text("GETS");
          2: push_text("GeT");
          default: push_text("/");
        endcase
      end
      default: push_text("GET");
    endcase
    push_delim();
    case ($urandom_range(0, 9))
      4, 5: push_text("/v");
      6: push_random_token(1, 4);
      7: ;
      8: push_random_token(13, 20);
      9: begin
        case ($urandom_range(0, 2))
          0: push_text("/vv");
          1: push_text("v");
          default: push_text("//");
        endcase
      end
      default: push_text("/");
    endcase
    push_delim();
    case ($urandom_range(0, 9))
      7: push_random_token(1, 6);
      8: push_random_token(13, 20);
      9: ;
      default: push_text("HTTP/1.1");
    endcase
    case ($urandom_range(0, 9))
      7: push_text("\012");
      8: push_text(" \015\012");
      9: push_text(" x\012");
      default: push_text("\015\012");
    endcase
    repeat ($urandom_range(0, 2)) begin
      push_random_token(1, 6);
      push_text(": ");
      push_random_token(0, 8);
      push_text("\015\012");
    end
    if ($urandom_range(0, 2) == 0) push_text("\012");
    else push_text("\015\012");
  endtask

  // ---- sender: bursts of random length with random gaps ----
  logic  in_taken = 1'b0;
  bit    draining = 1'b0;
  int    burst_left = 20;
  int    gap_left = 0;
  stim_t head;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (draining) begin
        if (expected_results.size() == 0) draining = 1'b0;
        s_tvalid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_words[0].drain) begin
        head = pending_words.pop_front();
        draining = 1'b1;
        drains_done++;
        s_tvalid <= 1'b0;
      end else begin
        head = pending_words.pop_front();
        s_tdata  <= head.value;
        s_tuser  <= head.kind;
        s_tvalid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // ---- receiver: stall pattern in modes, plus one long hold-off ----
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_CYCLES) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 150);
      end
      rx_mode_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ((rx_cycle % 5) < 2);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---- monitor, checker and watchdog ----
  result_t got;
  result_t want;
  result_t res;
  bit      emits;

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[4:0]);
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %h arrived with nothing expected", m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.route !== want.route || got.status !== want.status ||
              got.aborted !== want.aborted || m_tdata[7:5] !== 3'b000)
            note_failure($sformatf(
              "result %0d: got route %0d status %0d aborted %0d pad %b, want %0d %0d %0d",
              results_seen, got.route, got.status, got.aborted, m_tdata[7:5],
              want.route, want.status, want.aborted));
          if (want.aborted) aborted_seen++;
          else status_seen[want.status]++;
          if (want.route == RT_ROOT) roots_seen++;
          if (want.route == RT_VERSION) versions_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        words_taken++;
        if (s_tuser == KIND_CLOSE) closes_taken++;
        parse_word(kind_t'(s_tuser), s_tdata, emits, res);
        if (emits) expected_results.push_back(res);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: no word moved for %0d cycles", QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    tok_len = 0;
    start_request();

    // Directed: a good request with CRs, a disconnect, a lone blank line, a
    // newline in the method with zero and all-ones bytes, and an empty URI token.
    push_text("GET /v x\015\012\015\012");
    push_word(KIND_CLOSE, 8'hFF);
    push_text("\012");
    push_req_byte(CH_G);
    push_req_byte(8'h00);
    push_req_byte(8'hFF);
    push_text("\012\012");
    push_text("GET  \012\012");

    while (words_queued < WORD_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        repeat ($urandom_range(3, 24)) begin
          case ($urandom_range(0, 5))
            2: push_word(KIND_BYTE, CH_SPACE);
            3: push_word(KIND_BYTE, CH_LF);
            4: push_word(KIND_BYTE, CH_CR);
            5: push_word(KIND_BYTE, token_char());
            default: push_word(KIND_BYTE, 8'($urandom_range(0, 255)));
          endcase
        end
      end else if (pick == 2) begin
        push_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end else begin
        push_request();
      end
      if (words_queued >= drain_at) begin
        head = '0;
        head.drain = 1'b1;
        pending_words.push_back(head);
        drain_at += 150;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_words.size() == 0);
    @(posedge clk);
    wait (!s_tvalid);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("testbench: %0d words in (%0d disconnects), %0d results, %0d drain pauses",
             words_taken, closes_taken, results_seen, drains_done);
    $display("testbench: ok %0d (root %0d, /v %0d), 400 %0d, 404 %0d, 405 %0d, aborted %0d",
             status_seen[ST_OK], roots_seen, versions_seen, status_seen[ST_BAD],
             status_seen[ST_NOT_FOUND], status_seen[ST_NOT_ALLOWED], aborted_seen);
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: %0d mismatches", failures);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
